[design/sm3c_pkg.sv]
`default_nettype none
package sm3c_pkg;
  localparam int unsigned QueueDepth = 2;
  localparam logic [31:0] TLow  = 32'h79CC4519;
  localparam logic [31:0] THigh = 32'h7A879D8A;

  typedef enum logic [1:0] {
    KIND_WRITE  = 2'd0,
    KIND_ABSORB = 2'd1,
    KIND_READ   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    OP_WRITE    = 2'd0,
    OP_ABSORB   = 2'd1,
    OP_COMPRESS = 2'd2,
    OP_READ     = 2'd3
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [3:0]  widx;
    logic [31:0] data;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_LOAD  = 2'd1,
    ST_ROUND = 2'd2,
    ST_FOLD  = 2'd3
  } state_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] p0(input logic [31:0] x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic logic [31:0] p1(input logic [31:0] x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction
endpackage
`default_nettype wire

[design/sm3c_front.sv]
`default_nettype none
module sm3c_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [1:0]    in_kind,
  input  wire logic [2:0]    in_word_index,
  input  wire logic [31:0]   in_data_word,
  output logic               q_valid,
  input  wire logic          q_stall,
  output sm3c_pkg::cmd_t     q_cmd
);
  sm3c_pkg::cmd_t     slot_r [sm3c_pkg::QueueDepth];
  logic [1:0]         cnt_r, cnt_nxt;
  logic               rd_r, rd_nxt, wr_r, wr_nxt;
  logic [3:0]         words_r, words_nxt;
  logic               push, pop;
  sm3c_pkg::cmd_t     cmd;

  assign in_stall = (cnt_r == 2'(sm3c_pkg::QueueDepth));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = slot_r[rd_r];
  assign pop      = q_valid && !q_stall;

  always_comb begin
    cmd.widx = {1'b0, in_word_index};
    cmd.data = in_data_word;
    words_nxt = words_r;
    case (sm3c_pkg::kind_t'(in_kind))
      sm3c_pkg::KIND_WRITE: cmd.op = sm3c_pkg::OP_WRITE;
      sm3c_pkg::KIND_READ:  cmd.op = sm3c_pkg::OP_READ;
      sm3c_pkg::KIND_ABSORB: begin
        cmd.widx = words_r;
        cmd.op = (words_r == 4'd15) ? sm3c_pkg::OP_COMPRESS : sm3c_pkg::OP_ABSORB;
        if (push) words_nxt = words_r + 4'd1;
      end
      default: cmd.op = sm3c_pkg::OP_ABSORB;
    endcase
  end

  wire keep = push && (sm3c_pkg::kind_t'(in_kind) != sm3c_pkg::KIND_NONE);

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, keep} - {1'b0, pop};
    wr_nxt  = wr_r ^ keep;
    rd_nxt  = rd_r ^ pop;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; rd_r <= 1'b0; wr_r <= 1'b0; words_r <= '0;
    end else begin
      cnt_r <= cnt_nxt; rd_r <= rd_nxt; wr_r <= wr_nxt; words_r <= words_nxt;
    end
    if (keep) slot_r[wr_r] <= cmd;
  end

`ifndef ASSERT_OFF
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(sm3c_pkg::QueueDepth)) else $error("queue overflow");
  a_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 || cnt_r == 2'd2) |-> (rd_r == wr_r)) else $error("pointer skew");
  a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (keep && cmd.op == sm3c_pkg::OP_COMPRESS) |=> (words_r == 4'd0)) else $error("counter wrap");
`endif
endmodule
`default_nettype wire

[design/sm3c_back.sv]
`default_nettype none
module sm3c_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_valid,
  output logic               q_stall,
  input  wire sm3c_pkg::cmd_t q_cmd,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [31:0]        out_digest_word,
  output logic [2:0]         out_digest_index
);
  logic [31:0] v_r [8];
  logic [31:0] w_r [16];
  logic [31:0] a_r, b_r, c_r, d_r, e_r, f_r, g_r, h_r;
  sm3c_pkg::state_t st_r, st_nxt;
  logic [5:0]  j_r;
  logic [31:0] tj_r;
  logic        ov_r;
  logic [31:0] ow_r;
  logic [2:0]  oi_r;

  logic        take;
  logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, wn, wj, wpj;
  logic        lo;

  assign lo  = (j_r < 6'd16);
  assign wj  = w_r[0];
  assign wpj = w_r[0] ^ w_r[4];
  assign wn  = sm3c_pkg::p1(w_r[0] ^ w_r[7] ^ sm3c_pkg::rotl(w_r[13], 5'd15))
               ^ sm3c_pkg::rotl(w_r[3], 5'd7) ^ w_r[10];
  assign a12 = sm3c_pkg::rotl(a_r, 5'd12);
  assign ss1 = sm3c_pkg::rotl(a12 + e_r + tj_r, 5'd7);
  assign ss2 = ss1 ^ a12;
  assign ff  = lo ? (a_r ^ b_r ^ c_r) : ((a_r & b_r) | (a_r & c_r) | (b_r & c_r));
  assign gg  = lo ? (e_r ^ f_r ^ g_r) : ((e_r & f_r) | (~e_r & g_r));
  assign tt1 = ff + d_r + ss2 + wpj;
  assign tt2 = gg + h_r + ss1 + wj;

  always_comb begin
    st_nxt  = st_r;
    q_stall = 1'b1;
    take    = 1'b0;
    case (st_r)
      sm3c_pkg::ST_IDLE: begin
        q_stall = (q_cmd.op == sm3c_pkg::OP_READ) && ov_r && out_stall;
        take = q_valid && !q_stall;
        if (take && q_cmd.op == sm3c_pkg::OP_COMPRESS) st_nxt = sm3c_pkg::ST_LOAD;
      end
      sm3c_pkg::ST_LOAD:  st_nxt = sm3c_pkg::ST_ROUND;
      sm3c_pkg::ST_ROUND: if (j_r == 6'd63) st_nxt = sm3c_pkg::ST_FOLD;
      default:            st_nxt = sm3c_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= sm3c_pkg::ST_IDLE;
      ov_r <= 1'b0;
      for (int i = 0; i < 8; i++) v_r[i] <= '0;
    end else begin
      st_r <= st_nxt;
      if (ov_r && !out_stall) ov_r <= 1'b0;
      if (take && q_cmd.op == sm3c_pkg::OP_READ) begin
        ov_r <= 1'b1;
        ow_r <= v_r[q_cmd.widx[2:0]];
        oi_r <= q_cmd.widx[2:0];
      end
      if (take && q_cmd.op == sm3c_pkg::OP_WRITE) v_r[q_cmd.widx[2:0]] <= q_cmd.data;
      if (st_r == sm3c_pkg::ST_FOLD) begin
        v_r[0] <= v_r[0] ^ a_r; v_r[1] <= v_r[1] ^ b_r;
        v_r[2] <= v_r[2] ^ c_r; v_r[3] <= v_r[3] ^ d_r;
        v_r[4] <= v_r[4] ^ e_r; v_r[5] <= v_r[5] ^ f_r;
        v_r[6] <= v_r[6] ^ g_r; v_r[7] <= v_r[7] ^ h_r;
      end
    end
    if (take && (q_cmd.op == sm3c_pkg::OP_ABSORB || q_cmd.op == sm3c_pkg::OP_COMPRESS))
      w_r[q_cmd.widx] <= q_cmd.data;
    if (st_r == sm3c_pkg::ST_LOAD) begin
      a_r <= v_r[0]; b_r <= v_r[1]; c_r <= v_r[2]; d_r <= v_r[3];
      e_r <= v_r[4]; f_r <= v_r[5]; g_r <= v_r[6]; h_r <= v_r[7];
      j_r <= '0;
      tj_r <= sm3c_pkg::TLow;
    end
    if (st_r == sm3c_pkg::ST_ROUND) begin
      d_r <= c_r; c_r <= sm3c_pkg::rotl(b_r, 5'd9); b_r <= a_r; a_r <= tt1;
      h_r <= g_r; g_r <= sm3c_pkg::rotl(f_r, 5'd19); f_r <= e_r; e_r <= sm3c_pkg::p0(tt2);
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= wn;
      j_r <= j_r + 6'd1;
      tj_r <= (j_r == 6'd15) ? sm3c_pkg::rotl(sm3c_pkg::THigh, 5'd16)
                             : sm3c_pkg::rotl(tj_r, 5'd1);
    end
  end

  assign out_valid        = ov_r;
  assign out_digest_word  = ow_r;
  assign out_digest_index = oi_r;

`ifndef ASSERT_OFF
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != sm3c_pkg::ST_IDLE) |-> q_stall) else $error("take while busy");
  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == sm3c_pkg::ST_ROUND && j_r == 6'd63) |=> (st_r == sm3c_pkg::ST_FOLD))
    else $error("round count");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && out_stall) |=> (ov_r && $stable(ow_r))) else $error("result lost");
`endif
endmodule
`default_nettype wire

[design/sm3_compression_unit.sv]
// channel | beat contents                        | handshake
// in      | in_kind, in_word_index, in_data_word | in_valid / in_stall
// out     | out_digest_word, out_digest_index    | out_valid / out_stall
// Writes, absorbs and reads are executed by the back end; a 2-entry queue
// decouples them from the input. The sixteenth word starts the compression
// (load, 64 rounds of the single round unit, fold), which blocks the back end.
// rst_n is synchronous; no clearing pass. A stalled read result holds later reads.
`default_nettype none
module sm3_compression_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_kind,
  input  wire logic [2:0]  in_word_index,
  input  wire logic [31:0] in_data_word,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_digest_word,
  output logic [2:0]       out_digest_index
);
  logic           q_valid, q_stall;
  sm3c_pkg::cmd_t q_cmd;

  sm3c_front u_front (.clk, .rst_n, .in_valid, .in_stall, .in_kind, .in_word_index,
                      .in_data_word, .q_valid, .q_stall, .q_cmd);
  sm3c_back u_back (.clk, .rst_n, .q_valid, .q_stall, .q_cmd, .out_valid, .out_stall,
                    .out_digest_word, .out_digest_index);
endmodule
`default_nettype wire

[tb/sv/sm3_compression_unit_tb.sv]
`default_nettype none
module sm3_compression_unit_tb;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
  } digest_beat_t;

  class digest_scoreboard;
    logic [31:0] chain[8];
    logic [31:0] window[16];
    int unsigned fill;
    digest_beat_t pending[$];
    int unsigned errors;

    function new();
      foreach (chain[i]) chain[i] = '0;
      fill = 0;
      errors = 0;
    endfunction

    function logic [31:0] rol(logic [31:0] x, int n);
      n = n % 32;
      if (n == 0) return x;
      return (x << n) | (x >> (32 - n));
    endfunction

    function void compress();
      logic [31:0] w[68];
      logic [31:0] v[8];
      logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, t, x;
      for (int j = 0; j < 16; j++) w[j] = window[j];
      for (int j = 16; j < 68; j++) begin
        x = w[j-16] ^ w[j-9] ^ rol(w[j-3], 15);
        w[j] = x ^ rol(x, 15) ^ rol(x, 23) ^ rol(w[j-13], 7) ^ w[j-6];
      end
      for (int j = 0; j < 8; j++) v[j] = chain[j];
      for (int j = 0; j < 64; j++) begin
        t = (j < 16) ? sm3c_pkg::TLow : sm3c_pkg::THigh;
        a12 = rol(v[0], 12);
        ss1 = rol(a12 + v[4] + rol(t, j % 32), 7);
        ss2 = ss1 ^ a12;
        if (j < 16) begin
          ff = v[0] ^ v[1] ^ v[2];
          gg = v[4] ^ v[5] ^ v[6];
        end else begin
          ff = (v[0] & v[1]) | (v[0] & v[2]) | (v[1] & v[2]);
          gg = (v[4] & v[5]) | (~v[4] & v[6]);
        end
        tt1 = ff + v[3] + ss2 + (w[j] ^ w[j+4]);
        tt2 = gg + v[7] + ss1 + w[j];
        v[3] = v[2]; v[2] = rol(v[1], 9); v[1] = v[0]; v[0] = tt1;
        v[7] = v[6]; v[6] = rol(v[5], 19); v[5] = v[4];
        v[4] = tt2 ^ rol(tt2, 9) ^ rol(tt2, 17);
      end
      for (int j = 0; j < 8; j++) chain[j] ^= v[j];
    endfunction

    function void note_input(sm3c_pkg::kind_t k, logic [2:0] idx, logic [31:0] data);
      digest_beat_t e;
      case (k)
        sm3c_pkg::KIND_WRITE: chain[idx] = data;
        sm3c_pkg::KIND_ABSORB: begin
          window[fill] = data;
          if (fill == 15) begin
            compress();
            fill = 0;
          end else begin
            fill++;
          end
        end
        sm3c_pkg::KIND_READ: begin
          e.word = chain[idx];
          e.idx = idx;
          pending.push_back(e);
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [31:0] word, logic [2:0] idx);
      digest_beat_t e;
      if (pending.size() == 0) begin
        report("unexpected digest beat", 0, word);
        return;
      end
      e = pending.pop_front();
      if (word !== e.word) report("digest_word", e.word, word);
      if (idx !== e.idx) report("digest_index", e.idx, idx);
    endfunction

    function void report(string what, logic [31:0] exp_v, logic [31:0] got_v);
      $display("MISMATCH %s: expected %h got %h", what, exp_v, got_v);
      errors++;
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall;
  logic [1:0] in_kind;
  logic [2:0] in_word_index;
  logic [31:0] in_data_word;
  logic out_valid, out_stall;
  logic [31:0] out_digest_word;
  logic [2:0] out_digest_index;

  digest_scoreboard sb;
  bit calm;
  int unsigned idle_cycles;
  localparam int unsigned WatchdogLimit = 5000;

  sm3_compression_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_kind(in_kind), .in_word_index(in_word_index), .in_data_word(in_data_word),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_digest_word(out_digest_word), .out_digest_index(out_digest_index)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    sb = new();
    in_valid = 0;
    in_kind = sm3c_pkg::KIND_WRITE;
    in_word_index = '0;
    in_data_word = '0;
    out_stall = 0;
    idle_cycles = 0;
    calm = 0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        sb.note_input(sm3c_pkg::kind_t'(in_kind), in_word_index, in_data_word);
      if (out_valid && !out_stall)
        sb.check_result(out_digest_word, out_digest_index);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= (!calm && $urandom_range(99) < 15);
  end

  task automatic send_beat(sm3c_pkg::kind_t k, logic [2:0] idx, logic [31:0] data);
    while (!calm && $urandom_range(99) < 15) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_kind <= k;
    in_word_index <= idx;
    in_data_word <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  task automatic send_block(logic [31:0] fillv, bit rnd);
    for (int i = 0; i < 16; i++)
      send_beat(sm3c_pkg::KIND_ABSORB, 3'd0, rnd ? $urandom() : fillv);
  endtask

  task automatic read_all();
    for (int i = 0; i < 8; i++) send_beat(sm3c_pkg::KIND_READ, 3'(i), $urandom());
  endtask

  initial begin
    sm3c_pkg::kind_t k;
    rst_n = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: reads after reset, extremes, ignored kind, full blocks
    send_beat(sm3c_pkg::KIND_READ, 3'd0, 32'h0);
    send_beat(sm3c_pkg::KIND_READ, 3'd7, 32'hFFFF_FFFF);
    send_beat(sm3c_pkg::KIND_WRITE, 3'd0, 32'hFFFF_FFFF);
    send_beat(sm3c_pkg::KIND_WRITE, 3'd7, 32'h0000_0000);
    send_beat(sm3c_pkg::KIND_NONE, 3'd5, 32'hDEAD_BEEF);
    send_beat(sm3c_pkg::KIND_READ, 3'd0, 32'h0);
    send_block(32'hFFFF_FFFF, 0);
    read_all();
    for (int i = 0; i < 8; i++)
      send_beat(sm3c_pkg::KIND_WRITE, 3'(i), 32'h7380166F + i);
    send_block(32'h0, 0);
    send_beat(sm3c_pkg::KIND_READ, 3'd4, 32'h0);

    // drain: sender waits for every outstanding read
    drain();

    // random: mostly complete blocks with interleaved reads and writes
    for (int n = 0; n < 1000; n++) begin
      calm = (n >= 300 && n < 450);
      k = sm3c_pkg::kind_t'($urandom_range(99) < 70 ? sm3c_pkg::KIND_ABSORB :
                            $urandom_range(99) < 50 ? sm3c_pkg::KIND_READ :
                            $urandom_range(99) < 85 ? sm3c_pkg::KIND_WRITE :
                                                      sm3c_pkg::KIND_NONE);
      send_beat(k, 3'($urandom_range(7)), $urandom());
      if (n == 600) drain();
    end
    calm = 0;
    read_all();

    drain();
    repeat (100) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire

[sim.f]
design/sm3c_pkg.sv
design/sm3c_front.sv
design/sm3c_back.sv
design/sm3_compression_unit.sv
tb/sv/sm3_compression_unit_tb.sv
